@@ hdl/mfrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfrc_pkg
// Shared types, codes and constants of the meter frame receive checker.
// ----------------------------------------------------------------------------
package mfrc_pkg;

    localparam int POS_W = 9;
    localparam logic [POS_W-1:0] POS_MAX = 9'd511;
    localparam logic [POS_W-1:0] MIN_FRAME = 9'd15;
    localparam logic [7:0] MAX_COUNT = 8'd250;
    localparam logic [7:0] START_MARK = 8'h68;
    localparam logic [7:0] END_MARK = 8'h16;
    localparam logic [POS_W-1:0] START_MARK_POS = 9'd0;
    localparam logic [POS_W-1:0] COUNT_POS = 9'd2;
    localparam logic [POS_W-1:0] END_MARK_POS = 9'd34;
    localparam logic [POS_W-1:0] PAIR_BASE = 9'd3;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic {
        OP_RECEIVE = 1'b0,
        OP_READ    = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_TOO_SHORT = 3'd2,
        ST_CRC_ERROR = 3'd3,
        ST_MARKER    = 3'd4,
        ST_BAD_COUNT = 3'd5
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] count;
    } verdict_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_READ,
        CS_COPY,
        CS_DRAIN
    } ctrl_state_t;

    // CRC-16/Modbus, one byte, reflected
    function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/mfrc_cmd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfrc_cmd_if
// Command channel: frame byte receive or register image read, valid/ready.
// ----------------------------------------------------------------------------
interface mfrc_cmd_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [5:0] read_index;

    modport source (output valid, operation, data_byte, last_byte, read_index, input ready);
    modport sink (input valid, operation, data_byte, last_byte, read_index, output ready);
endinterface

`default_nettype wire

@@ hdl/mfrc_result_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfrc_result_if
// Result channel: frame verdict or image read data, valid/ready.
// ----------------------------------------------------------------------------
interface mfrc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  register_bytes;
    logic [15:0] accepted_count;
    logic [7:0]  read_data;

    modport source (output valid, status, register_bytes, accepted_count, read_data, input ready);
    modport sink (input valid, status, register_bytes, accepted_count, read_data, output ready);
endinterface

`default_nettype wire

@@ hdl/meter_frame_receive_check_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// meter_frame_receive_check_core
// Modbus-CRC reply frame receiver with register image and read access.
// ----------------------------------------------------------------------------
// Frame byte beats: one per cycle while idle and the result is free, no result except on the final beat.
// Rejected final beat: result is registered in the cycle after acceptance.
// Accepted final beat: pair copy reads the frame RAM one byte a cycle for count
//   rounded up to even bytes, then drains; result follows, input stalled meanwhile.
// Image read: image RAM read data is registered, then loaded into the result.
// Reset is asynchronous and clears control state; RAMs are not cleared, fill
//   counts make never-written entries read as zero, so no clearing pass.
// ----------------------------------------------------------------------------
module meter_frame_receive_check_core import mfrc_pkg::*; #(
    parameter int FRAME_BYTES = 256,
    parameter int IMAGE_BYTES = 64
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mfrc_cmd_if.sink     cmd,
    mfrc_result_if.source result
);

    localparam int FRAME_AW = $clog2(FRAME_BYTES);
    localparam int FILL_W   = $clog2(FRAME_BYTES + 1);
    localparam int IMAGE_AW = $clog2(IMAGE_BYTES);
    localparam int IFILL_W  = $clog2(IMAGE_BYTES + 1);

    ctrl_state_t state_reg, state_next;

    logic [7:0]         m_reg, m_next;
    logic [7:0]         count_reg, count_next;
    logic [15:0]        acc_reg, acc_next;
    logic               wr_valid_reg;
    logic [7:0]         wr_idx_reg;
    logic               wr_ok_reg;
    logic               rd_ok_reg;
    logic [IFILL_W-1:0] img_fill_reg, img_fill_next;

    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [7:0]         rbytes_reg, rbytes_next;
    logic [15:0]        acount_reg, acount_next;
    logic [7:0]         rdata_reg, rdata_next;

    logic               cmd_take;
    logic               is_read;
    logic               rx_take;
    logic               out_free;
    logic               load_reject;
    logic               load_read;
    logic               load_done;
    logic               copy_issue;
    logic               start_copy;
    logic [7:0]         m_last;
    logic [POS_W-1:0]   src;

    logic               fwr_en;
    logic [FRAME_AW-1:0] fwr_addr;
    logic [FILL_W-1:0]  frame_fill;
    verdict_t           verdict;
    logic [7:0]         frame_rd;

    logic               iwr_en;
    logic [7:0]         iwr_data;
    logic [7:0]         img_rd;

    assign cmd_take   = cmd.valid && cmd.ready;
    assign is_read    = op_t'(cmd.operation) == OP_READ;
    assign rx_take    = cmd_take && !is_read;
    assign out_free   = !out_valid_reg || result.ready;
    assign start_copy = rx_take && cmd.last_byte && verdict.status == ST_OK;
    assign m_last     = count_reg[0] ? count_reg : count_reg - 8'd1;
    assign src        = {1'b0, m_reg ^ 8'd1} + PAIR_BASE;

    mfrc_rx_check #(
        .FRAME_BYTES(FRAME_BYTES),
        .IMAGE_BYTES(IMAGE_BYTES)
    ) u_rx_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (rx_take),
        .data_byte(cmd.data_byte),
        .last_byte(cmd.last_byte),
        .wr_en    (fwr_en),
        .wr_addr  (fwr_addr),
        .fill     (frame_fill),
        .verdict  (verdict)
    );

    mfrc_ram #(
        .DEPTH(FRAME_BYTES)
    ) u_frame_ram (
        .clk    (clk),
        .wr_en  (fwr_en),
        .wr_addr(fwr_addr),
        .wr_data(cmd.data_byte),
        .rd_addr(src[FRAME_AW-1:0]),
        .rd_data(frame_rd)
    );

    assign iwr_en   = wr_valid_reg && wr_idx_reg < 8'(IMAGE_BYTES);
    assign iwr_data = wr_ok_reg ? frame_rd : 8'h00;

    mfrc_ram #(
        .DEPTH(IMAGE_BYTES)
    ) u_image_ram (
        .clk    (clk),
        .wr_en  (iwr_en),
        .wr_addr(wr_idx_reg[IMAGE_AW-1:0]),
        .wr_data(iwr_data),
        .rd_addr(IMAGE_AW'(cmd.read_index)),
        .rd_data(img_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (cmd_take && is_read)
                begin
                    state_next = CS_READ;
                end
                else if (start_copy)
                begin
                    state_next = CS_COPY;
                end
            end
            CS_READ:
            begin
                state_next = CS_IDLE;
            end
            CS_COPY:
            begin
                if (m_reg == m_last)
                begin
                    state_next = CS_DRAIN;
                end
            end
            CS_DRAIN:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd.ready   = 1'b0;
        load_reject = 1'b0;
        load_read   = 1'b0;
        load_done   = 1'b0;
        copy_issue  = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                cmd.ready   = out_free;
                load_reject = rx_take && cmd.last_byte && verdict.status != ST_OK;
            end
            CS_READ:
            begin
                load_read = 1'b1;
            end
            CS_COPY:
            begin
                copy_issue = 1'b1;
            end
            CS_DRAIN:
            begin
                load_done = 1'b1;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_next     = copy_issue ? m_reg + 8'd1 : 8'd0;
        count_next = (rx_take && cmd.last_byte) ? verdict.count : count_reg;
        acc_next   = start_copy ? acc_reg + 16'd1 : acc_reg;

        img_fill_next = img_fill_reg;
        if (iwr_en && wr_idx_reg >= 8'(img_fill_reg))
        begin
            img_fill_next = IFILL_W'(wr_idx_reg + 8'd1);
        end

        out_valid_next = out_valid_reg && !result.ready;
        status_next    = status_reg;
        rbytes_next    = rbytes_reg;
        acount_next    = acount_reg;
        rdata_next     = rdata_reg;
        priority if (load_reject)
        begin
            out_valid_next = 1'b1;
            status_next    = verdict.status;
            rbytes_next    = verdict.count;
            acount_next    = acc_reg;
            rdata_next     = 8'h00;
        end
        else if (load_read)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            rbytes_next    = 8'h00;
            acount_next    = acc_reg;
            rdata_next     = rd_ok_reg ? img_rd : 8'h00;
        end
        else if (load_done)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            rbytes_next    = count_reg;
            acount_next    = acc_reg;
            rdata_next     = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            acc_reg       <= '0;
            img_fill_reg  <= '0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            img_fill_reg  <= img_fill_next;
            wr_valid_reg  <= copy_issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        count_reg  <= count_next;
        wr_idx_reg <= m_reg;
        wr_ok_reg  <= src < POS_W'(frame_fill);
        if (cmd_take)
        begin
            rd_ok_reg <= 8'(cmd.read_index) < 8'(img_fill_reg);
        end
        status_reg <= status_next;
        rbytes_reg <= rbytes_next;
        acount_reg <= acount_next;
        rdata_reg  <= rdata_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.register_bytes = rbytes_reg;
    assign result.accepted_count = acount_reg;
    assign result.read_data      = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/mfrc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfrc_ram
// Simple dual-port byte RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfrc_ram #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/mfrc_rx_check.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mfrc_rx_check
// Byte position, CRC and marker tracking; frame verdict on the final beat.
// ----------------------------------------------------------------------------
module mfrc_rx_check import mfrc_pkg::*; #(
    parameter int FRAME_BYTES = 256,
    parameter int IMAGE_BYTES = 64,
    localparam int FRAME_AW = $clog2(FRAME_BYTES),
    localparam int FILL_W = $clog2(FRAME_BYTES + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_byte,
    output logic                     wr_en,
    output logic      [FRAME_AW-1:0] wr_addr,
    output logic      [FILL_W-1:0]   fill,
    output verdict_t                 verdict
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              ovf_reg, ovf_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        b0_reg, b0_next;
    logic [7:0]        b2_reg, b2_next;
    logic [7:0]        b34_reg, b34_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic [POS_W-1:0]  len;
    logic              in_store;
    logic              ovf_now;
    logic [15:0]       crc_now;

    assign in_store = pos_reg < POS_W'(FRAME_BYTES);
    assign wr_en    = take && in_store;
    assign wr_addr  = pos_reg[FRAME_AW-1:0];
    assign fill     = fill_reg;
    assign len      = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 9'd1;
    assign ovf_now  = ovf_reg || !in_store;
    assign crc_now  = crc16_add(crc_reg, data_byte);

    always_comb
    begin
        b0_next  = (wr_en && pos_reg == START_MARK_POS) ? data_byte : b0_reg;
        b2_next  = (wr_en && pos_reg == COUNT_POS) ? data_byte : b2_reg;
        b34_next = (wr_en && pos_reg == END_MARK_POS) ? data_byte : b34_reg;
        fill_next = fill_reg;
        if (wr_en && pos_reg >= POS_W'(fill_reg))
        begin
            fill_next = FILL_W'(pos_reg + 9'd1);
        end
        pos_next = pos_reg;
        ovf_next = ovf_reg;
        crc_next = crc_reg;
        if (take)
        begin
            if (last_byte)
            begin
                pos_next = '0;
                ovf_next = 1'b0;
                crc_next = CRC_INIT;
            end
            else
            begin
                pos_next = len;
                ovf_next = ovf_now;
                crc_next = crc_now;
            end
        end
    end

    always_comb
    begin
        verdict.count = '0;
        priority if (ovf_now || len > POS_W'(FRAME_BYTES))
        begin
            verdict.status = ST_TOO_LONG;
        end
        else if (len < MIN_FRAME)
        begin
            verdict.status = ST_TOO_SHORT;
        end
        else if (crc_now != 16'h0000)
        begin
            verdict.status = ST_CRC_ERROR;
        end
        else if (b0_next != START_MARK || b34_next != END_MARK)
        begin
            verdict.status = ST_MARKER;
        end
        else if (b2_next == 8'd0 || b2_next > MAX_COUNT || b2_next > 8'(IMAGE_BYTES))
        begin
            verdict.status = ST_BAD_COUNT;
            verdict.count  = b2_next;
        end
        else
        begin
            verdict.status = ST_OK;
            verdict.count  = b2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            ovf_reg  <= 1'b0;
            crc_reg  <= CRC_INIT;
            b0_reg   <= '0;
            b2_reg   <= '0;
            b34_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            ovf_reg  <= ovf_next;
            crc_reg  <= crc_next;
            b0_reg   <= b0_next;
            b2_reg   <= b2_next;
            b34_reg  <= b34_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire
